[rtl/core/residual_magnitude_statistics_assert.svh]
// Assertion macros used by the residual magnitude statistics top level.
`ifndef RESIDUAL_MAGNITUDE_STATISTICS_ASSERT_SVH
`define RESIDUAL_MAGNITUDE_STATISTICS_ASSERT_SVH

// Condition c holds in the same cycle as a.
`define RMS_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Condition c holds in the cycle after a.
`define RMS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/rms_pkg.sv]
// Shared constants for the residual magnitude statistics block.
package rms_pkg;
  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int VAL_W     = 24;
  localparam int SQ_W      = 2 * VAL_W;
  localparam int SUM_W     = VAL_W + CNT_W - 1;
  localparam int SQSUM_W   = SQ_W + CNT_W - 1;
  localparam int ROOT_W    = (SQSUM_W + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int DIVCNT_W  = $clog2(RAD_W);
  localparam int BITPOS_W  = $clog2(VAL_W);
endpackage

[rtl/core/residual_magnitude_statistics.sv]
// Top level of the residual magnitude statistics block.
// One vector is taken at a time: a beat is accepted only while the engine is
// idle. Then come the squaring states (multiply, then add) and the bit-serial
// square root, which yields 29 result bits. A store state follows, and the
// block returns to idle to accept the next beat, so a new vector is not taken
// before the last is through the shared root unit. A beat marked last closes
// the set: a set-up state, then two restoring divisions (mean and mean square),
// then a second root pass (a start state, then the root). Last is a radix
// selection of the median that scans the magnitude RAM once per result bit,
// and an emit state loads the output register.
// Min and max are tracked as vectors are stored. The result goes into an
// output register, so the next set can start while it waits to be taken.
// Vectors beyond the RAM depth are dropped and flagged in overflowed.
module residual_magnitude_statistics import rms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [23:0] residual_x,
  input  logic signed [23:0] residual_y,
  input  logic              last_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [23:0]       min_value,
  output logic [23:0]       max_value,
  output logic [23:0]       median_value,
  output logic [23:0]       mean_value,
  output logic [23:0]       rms_value,
  output logic [10:0]       item_count,
  output logic              overflowed
);
`include "residual_magnitude_statistics_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_ROOT, S_STORE, S_DIV_INIT, S_DIV_MEAN,
    S_DIV_SQ, S_RMS_GO, S_ROOT_RMS, S_SCAN, S_DECIDE, S_EMIT
  } state_t;

  state_t state;

  // Per-vector working registers
  logic [VAL_W-1:0]   ax, ay;
  logic [SQ_W-1:0]    px, py, sq;
  logic               last;

  // Set state
  logic [CNT_W-1:0]   stored_count;
  logic [SUM_W-1:0]   magnitude_sum;
  logic [SQSUM_W-1:0] square_sum;
  logic               dropped_flag;
  logic [VAL_W-1:0]   run_min, run_max;
  logic [VAL_W-1:0]   mean_reg, rms_reg;

  // Divider
  logic [RAD_W-1:0]    div_num;
  logic [CNT_W-1:0]    div_rem;
  logic [DIVCNT_W-1:0] div_cnt;
  logic [CNT_W:0]      div_sh;
  logic                div_q;
  logic [RAD_W-1:0]    div_num_next;

  // Median selection
  logic [BITPOS_W-1:0] bitpos;
  logic [CNT_W-1:0]    scan, sel_cnt, sel_k;
  logic                rd_pend;
  logic [VAL_W-1:0]    prefix;
  logic [VAL_W-1:0]    hi_mask;
  logic                hit;

  // Memory and root unit
  logic               ram_we, ram_re;
  logic [VAL_W-1:0]   ram_q;
  logic               root_start, root_done;
  logic [RAD_W-1:0]   root_in;
  logic [ROOT_W-1:0]  root_out;
  logic [VAL_W-1:0]   mag;
  logic               has_room;

  assign in_stall = (state != S_IDLE);
  assign has_room = stored_count < CNT_W'(DEPTH);
  assign mag      = root_out[VAL_W-1:0];

  assign ram_we = (state == S_STORE) && has_room;
  assign ram_re = (state == S_SCAN) && (scan < stored_count);

  assign root_start = (state == S_ADD) || (state == S_RMS_GO);
  assign root_in    = (state == S_ADD) ? RAD_W'(px + py) : div_num;

  assign div_sh       = {div_rem, div_num[RAD_W-1]};
  assign div_q        = div_sh >= {1'b0, stored_count};
  assign div_num_next = {div_num[RAD_W-2:0], div_q};

  assign hi_mask = {VAL_W{1'b1}} << ({1'b0, bitpos} + 1'b1);
  assign hit     = (((ram_q ^ prefix) & hi_mask) == '0) && !ram_q[bitpos];

  rms_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (stored_count[ADDR_W-1:0]),
    .wr_data (mag),
    .rd_en   (ram_re),
    .rd_addr (scan[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

  rms_isqrt u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (root_in),
    .done     (root_done),
    .root     (root_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stored_count  <= '0;
      magnitude_sum <= '0;
      square_sum    <= '0;
      dropped_flag  <= 1'b0;
      out_valid     <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      // Drop the held result once the beat is taken, unless a new one replaces it
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ax    <= residual_x[23] ? VAL_W'(-residual_x) : VAL_W'(residual_x);
            ay    <= residual_y[23] ? VAL_W'(-residual_y) : VAL_W'(residual_y);
            last  <= last_item;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          px    <= ax * ax;
          py    <= ay * ay;
          state <= S_ADD;
        end
        S_ADD: begin
          sq    <= px + py;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (has_room) begin
            stored_count  <= stored_count + 1'b1;
            magnitude_sum <= magnitude_sum + SUM_W'(mag);
            square_sum    <= square_sum + SQSUM_W'(sq);
            if (stored_count == '0 || mag < run_min) begin
              run_min <= mag;
            end
            if (stored_count == '0 || mag > run_max) begin
              run_max <= mag;
            end
          end else begin
            dropped_flag <= 1'b1;
          end
          state <= last ? S_DIV_INIT : S_IDLE;
        end
        S_DIV_INIT: begin
          div_num <= RAD_W'(magnitude_sum);
          div_rem <= '0;
          div_cnt <= DIVCNT_W'(RAD_W - 1);
          state   <= S_DIV_MEAN;
        end
        S_DIV_MEAN: begin
          if (div_cnt == '0) begin
            mean_reg <= div_num_next[VAL_W-1:0];
            div_num  <= RAD_W'(square_sum);
            div_rem  <= '0;
            div_cnt  <= DIVCNT_W'(RAD_W - 1);
            state    <= S_DIV_SQ;
          end else begin
            div_rem <= div_q ? CNT_W'(div_sh - {1'b0, stored_count}) : div_sh[CNT_W-1:0];
            div_num <= div_num_next;
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_DIV_SQ: begin
          div_rem <= div_q ? CNT_W'(div_sh - {1'b0, stored_count}) : div_sh[CNT_W-1:0];
          div_num <= div_num_next;
          if (div_cnt == '0) begin
            state <= S_RMS_GO;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_RMS_GO: begin
          state <= S_ROOT_RMS;
        end
        S_ROOT_RMS: begin
          if (root_done) begin
            rms_reg <= mag;
            prefix  <= '0;
            bitpos  <= BITPOS_W'(VAL_W - 1);
            sel_k   <= stored_count >> 1;
            sel_cnt <= '0;
            scan    <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= ram_re;
          if (ram_re) begin
            scan <= scan + 1'b1;
          end
          if (rd_pend && hit) begin
            sel_cnt <= sel_cnt + 1'b1;
          end
          if (!ram_re && !rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // Fix one result bit: go high when too few entries lie below
          if (sel_k >= sel_cnt) begin
            sel_k          <= sel_k - sel_cnt;
            prefix[bitpos] <= 1'b1;
          end
          sel_cnt <= '0;
          scan    <= '0;
          if (bitpos == '0) begin
            state <= S_EMIT;
          end else begin
            bitpos <= bitpos - 1'b1;
            state  <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            min_value     <= run_min;
            max_value     <= run_max;
            median_value  <= prefix;
            mean_value    <= mean_reg;
            rms_value     <= rms_reg;
            item_count    <= stored_count;
            overflowed    <= dropped_flag;
            stored_count  <= '0;
            magnitude_sum <= '0;
            square_sum    <= '0;
            dropped_flag  <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RMS_ASSERT_SAME(a_count_bound, 1'b1, stored_count <= CNT_W'(DEPTH))
  `RMS_ASSERT_SAME(a_count_nonzero, out_valid, item_count != '0)
  `RMS_ASSERT_SAME(a_order, out_valid,
                   min_value <= median_value && median_value <= max_value)
  `RMS_ASSERT_SAME(a_mean_range, out_valid,
                   min_value <= mean_value && mean_value <= max_value)
  `RMS_ASSERT_NEXT(a_clear, state == S_EMIT && (!out_valid || !out_stall),
                   stored_count == '0 && !dropped_flag)
endmodule

[rtl/core/rms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/core/rms_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module rms_isqrt import rms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              fits;

  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(ROOT_W - 1);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[RAD_W-3:0], 2'b00};
        rem  <= fits ? rem_sh - trial : rem_sh;
        root <= {root[ROOT_W-2:0], fits};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end
endmodule
